// ----- hdl/alu16f_pkg.sv -----
`default_nettype none

package alu16f_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam int KIND_W     = 5;
    localparam int FLAG_W     = 4;

    typedef enum logic [KIND_W-1:0] {
        OP_ADD   = 5'd0,
        OP_SUB   = 5'd1,
        OP_AND   = 5'd2,
        OP_OR    = 5'd3,
        OP_XOR   = 5'd4,
        OP_CMP   = 5'd5,
        OP_MUL   = 5'd6,
        OP_DIV   = 5'd7,
        OP_NOT   = 5'd8,
        OP_INC   = 5'd9,
        OP_DEC   = 5'd10,
        OP_SETZ  = 5'd11,
        OP_SETNZ = 5'd12,
        OP_SETL  = 5'd13,
        OP_SETLE = 5'd14,
        OP_SETG  = 5'd15,
        OP_SETGE = 5'd16,
        OP_SETB  = 5'd17,
        OP_SETBE = 5'd18,
        OP_SETA  = 5'd19,
        OP_SETAE = 5'd20
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DIV0  = 2'd1,
        ST_BADOP = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_MFIX,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [DATA_WIDTH-1:0] dest_value;
        logic [DATA_WIDTH-1:0] src_value;
    } t_in_item;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] result;
        logic                  write_back;
        logic [FLAG_W-1:0]     flags_out;
        t_status               status;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic take;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    // flags: bit0 zero, bit1 sign, bit2 overflow, bit3 carry
    function automatic logic set_cond(t_op op, logic [FLAG_W-1:0] f);
        logic z;
        logic s;
        logic o;
        logic c;
        logic v;
        z = f[0];
        s = f[1];
        o = f[2];
        c = f[3];
        unique case (op)
            OP_SETZ:  v = z;
            OP_SETNZ: v = !z;
            OP_SETL:  v = s != o;
            OP_SETLE: v = z || (s != o);
            OP_SETG:  v = !z && (s == o);
            OP_SETGE: v = s == o;
            OP_SETB:  v = c;
            OP_SETBE: v = c || z;
            OP_SETA:  v = !c && !z;
            default:  v = !c;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/alu16f_core.sv -----
`default_nettype none

module alu16f_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire alu16f_pkg::t_core_ctl             i_ctl,
    input  wire alu16f_pkg::t_in_item              i_item,
    input  wire logic [alu16f_pkg::FLAG_W-1:0]     i_flags,
    output alu16f_pkg::t_core_sts                  o_sts,
    output alu16f_pkg::t_out_item                  o_res
);
    import alu16f_pkg::*;

    localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_WIDTH - 1);

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [DATA_WIDTH-1:0] r_x, n_x;
    logic [DATA_WIDTH-1:0] r_y, n_y;
    logic [DATA_WIDTH-1:0] r_z, n_z;
    logic [DATA_WIDTH:0]   r_h, n_h;
    logic                  r_c, n_c;
    logic                  r_nz, n_nz;
    logic                  r_fc, n_fc;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [DATA_WIDTH-1:0] r_res, n_res;
    logic                  r_wb, n_wb;
    logic [FLAG_W-1:0]     r_flg, n_flg;
    t_status               r_st, n_st;

    t_op                   in_op;
    logic                  is_sub;
    logic                  is_arith;
    logic                  xb, yb, sum, co, lbit, sbit;
    logic [DATA_WIDTH:0]   msum;
    logic [DATA_WIDTH:0]   remc;
    logic [DATA_WIDTH+1:0] dsub;
    logic                  ge;
    logic [DATA_WIDTH-1:0] sel;
    logic [DATA_WIDTH-1:0] hdiff;
    logic [DATA_WIDTH-1:0] quo;

    assign in_op    = t_op'(i_item.kind);
    assign is_sub   = (r_op == OP_SUB) || (r_op == OP_CMP) || (r_op == OP_DEC);
    assign is_arith = is_sub || (r_op == OP_ADD) || (r_op == OP_INC);

    // one bit per cycle, LSB first
    assign xb  = r_x[0];
    assign yb  = r_y[0] ^ is_sub;
    assign sum = xb ^ yb ^ r_c;
    assign co  = (xb & yb) | (xb & r_c) | (yb & r_c);

    always_comb begin
        unique case (r_op)
            OP_AND:  lbit = xb & r_y[0];
            OP_OR:   lbit = xb | r_y[0];
            OP_XOR:  lbit = xb ^ r_y[0];
            default: lbit = ~xb;
        endcase
    end

    assign sbit = is_arith ? sum : lbit;

    // shift-add multiply step
    assign msum = r_h + (r_x[0] ? {1'b0, r_y} : '0);

    // restoring divide step
    assign remc = {r_h[DATA_WIDTH-1:0], r_x[DATA_WIDTH-1]};
    assign dsub = {1'b0, remc} - {2'b00, r_y};
    assign ge   = !dsub[DATA_WIDTH+1];
    assign quo  = {r_x[DATA_WIDTH-2:0], ge};

    // signed correction of the product's high half
    assign sel   = !r_cnt[0] ? (r_y[DATA_WIDTH-1] ? r_z : '0)
                             : (r_z[DATA_WIDTH-1] ? r_y : '0);
    assign hdiff = r_h[DATA_WIDTH-1:0] - sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_h   <= n_h;
        r_c   <= n_c;
        r_nz  <= n_nz;
        r_fc  <= n_fc;
        r_cnt <= n_cnt;
        r_res <= n_res;
        r_wb  <= n_wb;
        r_flg <= n_flg;
        r_st  <= n_st;
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_h     = r_h;
        n_c     = r_c;
        n_nz    = r_nz;
        n_fc    = r_fc;
        n_cnt   = r_cnt;
        n_res   = r_res;
        n_wb    = r_wb;
        n_flg   = r_flg;
        n_st    = r_st;
        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_op    = in_op;
                    n_x     = i_item.dest_value;
                    n_y     = i_item.src_value;
                    n_z     = i_item.src_value;
                    n_h     = '0;
                    n_c     = 1'b0;
                    n_nz    = 1'b0;
                    n_cnt   = '0;
                    n_res   = '0;
                    n_wb    = 1'b1;
                    n_st    = ST_OK;
                    n_flg   = i_flags;
                    n_state = S_CALC;
                    unique case (in_op)
                        OP_ADD, OP_AND, OP_OR, OP_XOR, OP_NOT: begin
                        end
                        OP_SUB, OP_CMP: begin
                            n_c = 1'b1;
                        end
                        OP_INC: begin
                            n_y = DATA_WIDTH'(1);
                        end
                        OP_DEC: begin
                            n_y = DATA_WIDTH'(1);
                            n_c = 1'b1;
                        end
                        OP_MUL: begin
                            n_x = i_item.src_value;
                            n_y = i_item.dest_value;
                        end
                        OP_DIV: begin
                            if (i_item.src_value == '0) begin
                                n_wb    = 1'b0;
                                n_st    = ST_DIV0;
                                n_state = S_HOLD;
                            end
                        end
                        OP_SETZ, OP_SETNZ, OP_SETL, OP_SETLE, OP_SETG,
                        OP_SETGE, OP_SETB, OP_SETBE, OP_SETA, OP_SETAE: begin
                            n_res   = {{(DATA_WIDTH-1){1'b0}}, set_cond(in_op, i_flags)};
                            n_state = S_HOLD;
                        end
                        default: begin
                            n_wb    = 1'b0;
                            n_st    = ST_BADOP;
                            n_state = S_HOLD;
                        end
                    endcase
                end
            end
            S_CALC: begin
                n_cnt = r_cnt + 1'b1;
                if (r_op == OP_MUL) begin
                    n_h = {1'b0, msum[DATA_WIDTH:1]};
                    n_x = {msum[0], r_x[DATA_WIDTH-1:1]};
                    if (r_cnt == LAST) begin
                        n_fc    = msum[1];
                        n_cnt   = '0;
                        n_state = S_MFIX;
                    end
                end else if (r_op == OP_DIV) begin
                    n_h = ge ? dsub[DATA_WIDTH:0] : remc;
                    n_x = quo;
                    if (r_cnt == LAST) begin
                        n_res   = quo;
                        n_flg   = {2'b00, quo[DATA_WIDTH-1], quo == '0};
                        n_state = S_HOLD;
                    end
                end else begin
                    n_x  = r_x >> 1;
                    n_y  = r_y >> 1;
                    n_h  = {1'b0, sbit, r_h[DATA_WIDTH-1:1]};
                    n_c  = co;
                    n_nz = r_nz | sbit;
                    if (r_cnt == LAST) begin
                        n_res = (r_op == OP_CMP) ? '0 : {sbit, r_h[DATA_WIDTH-1:1]};
                        n_wb  = r_op != OP_CMP;
                        if (is_arith) begin
                            n_flg = {is_sub ? !co : co, r_c ^ co, sbit, !(r_nz | sbit)};
                        end else begin
                            n_flg = {2'b00, sbit, !(r_nz | sbit)};
                        end
                        n_state = S_HOLD;
                    end
                end
            end
            S_MFIX: begin
                n_cnt = r_cnt + 1'b1;
                n_h   = {1'b0, hdiff};
                if (r_cnt[0]) begin
                    n_res   = r_x;
                    n_flg   = {r_fc, hdiff != {DATA_WIDTH{r_x[DATA_WIDTH-1]}},
                               r_x[DATA_WIDTH-1], r_x == '0};
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_ctl.take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_sts.busy = r_state != S_IDLE;
    assign o_sts.done = r_state == S_HOLD;

    assign o_res.result     = r_res;
    assign o_res.write_back = r_wb;
    assign o_res.flags_out  = r_flg;
    assign o_res.status     = r_st;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> r_state == S_IDLE)
        else $error("start while busy");

    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && !i_ctl.take) |=>
            (r_state == S_HOLD && $stable(r_res) && $stable(r_flg)))
        else $error("held result changed");

    a_calc_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC && r_cnt != LAST) |=> r_state == S_CALC)
        else $error("serial pass cut short");

    a_err_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_HOLD |-> !(r_wb && r_st != ST_OK))
        else $error("write-back on error");

endmodule

`default_nettype wire

// ----- hdl/alu16_with_flags_and_setcc.sv -----
// Add, sub, cmp, logic, inc, dec and div run a DATA_WIDTH-step shift loop in the bit-serial
// core (one bit or one quotient bit a cycle); mul follows its loop with signed correction
// steps; set-on-condition, invalid codes and divide by zero skip the loop. The output register
// lets the next item start while a beat waits. Synchronous active-low reset clears the stored
// flags and output valid, idles the core.
`default_nettype none

module alu16_with_flags_and_setcc (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire alu16f_pkg::t_in_item i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output alu16f_pkg::t_out_item     o_out_item
);
    import alu16f_pkg::*;

    logic [FLAG_W-1:0] r_flags;
    logic              r_valid;
    t_out_item         r_out;
    t_core_ctl         core_ctl;
    t_core_sts         core_sts;
    t_out_item         core_res;

    assign core_ctl.start = i_in_valid && !core_sts.busy;
    assign core_ctl.take  = core_sts.done && (!r_valid || !i_out_stall);

    alu16f_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_item  (i_in_item),
        .i_flags (r_flags),
        .o_sts   (core_sts),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_valid <= 1'b0;
        end else begin
            if (core_ctl.take) begin
                r_flags <= core_res.flags_out;
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_ctl.take) begin
            r_out <= core_res;
        end
    end

    assign o_in_stall  = core_sts.busy;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// ----- test/alu16_checker.sv -----
`timescale 1ns / 100ps

module alu16_checker (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire alu16f_pkg::t_in_item i_in_item,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire alu16f_pkg::t_out_item i_out_item,
    output int unsigned               o_fail_count,
    output int unsigned               o_pending
);
    import alu16f_pkg::*;

    t_out_item         expected_q[$];
    logic [FLAG_W-1:0] flags_q;
    int unsigned       fail_count;

    // flag layout {carry, overflow, sign, zero}
    function automatic logic [FLAG_W-1:0] flag_word(input logic carry, input logic ovf,
                                                    input logic [DATA_WIDTH-1:0] r);
        return {carry, ovf, r[DATA_WIDTH-1], r == '0};
    endfunction

    function automatic t_out_item alu_predict(input t_in_item it,
                                              input logic [FLAG_W-1:0] flags);
        t_out_item                      res;
        logic [DATA_WIDTH-1:0]          a;
        logic [DATA_WIDTH-1:0]          b;
        logic [DATA_WIDTH-1:0]          r;
        logic [DATA_WIDTH:0]            wide;
        logic [2*DATA_WIDTH-1:0]        prod;
        logic signed [2*DATA_WIDTH-1:0] sprod;
        logic                           z;
        logic                           s;
        logic                           o;
        logic                           c;
        logic                           v;
        a = it.dest_value;
        b = it.src_value;
        res.result     = '0;
        res.write_back = 1'b1;
        res.flags_out  = flags;
        res.status     = ST_OK;
        case (it.kind)
            OP_ADD, OP_INC: begin
                if (it.kind == OP_INC) b = DATA_WIDTH'(1);
                wide = {1'b0, a} + {1'b0, b};
                r = wide[DATA_WIDTH-1:0];
                res.result = r;
                res.flags_out = flag_word(wide[DATA_WIDTH],
                    ~(a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) & (a[DATA_WIDTH-1] ^ r[DATA_WIDTH-1]), r);
            end
            OP_SUB, OP_CMP, OP_DEC: begin
                if (it.kind == OP_DEC) b = DATA_WIDTH'(1);
                r = a - b;
                res.flags_out = flag_word(a < b,
                    (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) & (a[DATA_WIDTH-1] ^ r[DATA_WIDTH-1]), r);
                if (it.kind == OP_CMP) begin
                    res.write_back = 1'b0;
                end else begin
                    res.result = r;
                end
            end
            OP_AND, OP_OR, OP_XOR, OP_NOT: begin
                case (it.kind)
                    OP_AND:  r = a & b;
                    OP_OR:   r = a | b;
                    OP_XOR:  r = a ^ b;
                    default: r = ~a;
                endcase
                res.result = r;
                res.flags_out = flag_word(1'b0, 1'b0, r);
            end
            OP_MUL: begin
                prod = a * b;
                sprod = $signed(a) * $signed(b);
                r = prod[DATA_WIDTH-1:0];
                res.result = r;
                res.flags_out = flag_word(prod[DATA_WIDTH],
                    sprod > 32'sd32767 || sprod < -32'sd32768, r);
            end
            OP_DIV: begin
                if (b == '0) begin
                    res.write_back = 1'b0;
                    res.status = ST_DIV0;
                end else begin
                    r = a / b;
                    res.result = r;
                    res.flags_out = flag_word(1'b0, 1'b0, r);
                end
            end
            default: begin
                if (it.kind >= OP_SETZ && it.kind <= OP_SETAE) begin
                    z = flags[0];
                    s = flags[1];
                    o = flags[2];
                    c = flags[3];
                    case (it.kind)
                        OP_SETZ:  v = z;
                        OP_SETNZ: v = !z;
                        OP_SETL:  v = s ^ o;
                        OP_SETLE: v = z || (s ^ o);
                        OP_SETG:  v = !z && !(s ^ o);
                        OP_SETGE: v = !(s ^ o);
                        OP_SETB:  v = c;
                        OP_SETBE: v = c || z;
                        OP_SETA:  v = !c && !z;
                        default:  v = !c;
                    endcase
                    res.result = {{(DATA_WIDTH-1){1'b0}}, v};
                end else begin
                    res.write_back = 1'b0;
                    res.status = ST_BADOP;
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            flags_q = '0;
            expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected output beat: result=%h wb=%b flags=%h status=%0d",
                                 i_out_item.result, i_out_item.write_back,
                                 i_out_item.flags_out, i_out_item.status);
                end else begin
                    want = expected_q.pop_front();
                    if (want.result !== i_out_item.result
                            || want.write_back !== i_out_item.write_back
                            || want.flags_out !== i_out_item.flags_out
                            || want.status !== i_out_item.status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"beat mismatch: expected result=%h wb=%b flags=%h ",
                                      "status=%0d, got result=%h wb=%b flags=%h status=%0d"},
                                     want.result, want.write_back, want.flags_out,
                                     want.status, i_out_item.result, i_out_item.write_back,
                                     i_out_item.flags_out, i_out_item.status);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = alu_predict(i_in_item, flags_q);
                flags_q = want.flags_out;
                expected_q.push_back(want);
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import alu16f_pkg::*;

    localparam logic [KIND_W-1:0] KIND_BAD_LO = 5'd21;
    localparam logic [KIND_W-1:0] KIND_BAD_HI = 5'd31;
    localparam int                RAND_ITEMS  = 332;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_item    in_item   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_item;
    int unsigned fail_count;
    int unsigned pending_count;
    int          idle_pct  = 0;
    int          stall_pct = 0;

    always #2 clk = ~clk;

    alu16_with_flags_and_setcc i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    alu16_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always @(posedge clk) begin
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [DATA_WIDTH-1:0] a,
                             input logic [DATA_WIDTH-1:0] b);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{kind: kind, dest_value: a, src_value: b};
        do @(posedge clk); while (in_stall);
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 16'h0001;
            2:       return 16'h7fff;
            3:       return 16'h8000;
            4:       return 16'hffff;
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        int roll;
        roll = $urandom_range(99);
        if (roll < 6)
            return KIND_W'($urandom_range(KIND_BAD_LO, KIND_BAD_HI));
        else if (roll < 32)
            return KIND_W'($urandom_range(OP_SETZ, OP_SETAE));
        else
            return KIND_W'($urandom_range(OP_ADD, OP_DEC));
    endfunction

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(OP_ADD,   16'hffff, 16'h0001);
        send_beat(OP_ADD,   16'h7fff, 16'h0001);
        send_beat(OP_SETZ,  16'h0000, 16'h0000);
        send_beat(OP_SETL,  16'hffff, 16'hffff);
        send_beat(OP_SUB,   16'h0000, 16'h0001);
        send_beat(OP_SETB,  16'h0000, 16'h0000);
        send_beat(OP_SUB,   16'h8000, 16'h0001);
        send_beat(OP_SETGE, 16'h0000, 16'h0000);
        send_beat(OP_CMP,   16'h1234, 16'h1234);
        send_beat(OP_SETG,  16'h0000, 16'h0000);
        send_beat(OP_SETLE, 16'h0000, 16'h0000);
        send_beat(OP_SETNZ, 16'h0000, 16'h0000);
        send_beat(OP_AND,   16'hffff, 16'h0f0f);
        send_beat(OP_XOR,   16'hffff, 16'hffff);
        send_beat(OP_SETBE, 16'h0000, 16'h0000);
        send_beat(OP_SETA,  16'h0000, 16'h0000);
        send_beat(OP_SETAE, 16'h0000, 16'h0000);
        send_beat(OP_MUL,   16'h8000, 16'hffff);
        send_beat(OP_DIV,   16'hffff, 16'h0000);
        send_beat(OP_DIV,   16'hffff, 16'h0001);
        send_beat(OP_NOT,   16'h0000, 16'hffff);
        send_beat(OP_INC,   16'hffff, 16'h0000);
        send_beat(OP_DEC,   16'h8000, 16'h0000);
        send_beat(KIND_BAD_LO, 16'hffff, 16'hffff);
        send_beat(KIND_BAD_HI, 16'h0000, 16'h0000);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 64; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 64; end
                default: begin idle_pct = 32; stall_pct <= 32; end
            endcase
            repeat (RAND_ITEMS) send_beat(pick_kind(), pick_word(), pick_word());
        end
        in_valid <= 1'b0;

        repeat (2) @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("[alu16_with_flags_and_setcc] OK");
        else
            $display("[alu16_with_flags_and_setcc] ERROR");
        $finish;
    end

    initial begin
        #8000000;
        $display("[alu16_with_flags_and_setcc] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/alu16f_pkg.sv
hdl/alu16f_core.sv
hdl/alu16_with_flags_and_setcc.sv
test/alu16_checker.sv
test/tb_top.sv
